@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define CTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctc assertion failed");

// next-cycle implication, off during reset
`define CTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctc assertion failed");

`endif

@@ design/ctc_pkg.sv @@
`timescale 1ns / 1ps
package ctc_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int SC_LAT       = CORDIC_STEPS + 3;
    localparam int SQ_LAT       = 32;
    localparam int DIV_LAT      = 32;

    // ceil(2^31 / 45): exact floor(mag / 45) for 26-bit magnitudes
    localparam logic [25:0] RECIP_45 = 26'd47721859;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [2:0] {
        MODE_CART  = 3'd0,
        MODE_UNIT  = 3'd1,
        MODE_POLAR = 3'd2,
        MODE_UNSUP = 3'd3,
        MODE_SKY   = 3'd4,
        MODE_TAN   = 3'd5
    } t_mode;

    typedef logic [31:0] t_atan_tab [32];
    localparam t_atan_tab ATAN_TAB = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
        32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
        32'd81, 32'd40, 32'd20, 32'd10, 32'd5, 32'd2, 32'd1, 32'd0, 32'd0
    };

    // binary angle of a degree remainder below 45, rounded half up
    typedef logic [12:0] t_frac_tab [64];
    function automatic t_frac_tab fn_frac_tab();
        t_frac_tab t;
        for (int i = 0; i < 64; i++) begin
            if (i < 45) begin
                t[i] = 13'((i * 65536 + 180) / 360);
            end else begin
                t[i] = '0;
            end
        end
        return t;
    endfunction
    localparam t_frac_tab FRAC_TAB = fn_frac_tab();

    typedef struct packed {
        logic               valid;
        logic [2:0]         mode;
        logic               fail;
        logic               resc;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_side;

    function automatic logic [31:0] fn_abs32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // quotient magnitude (at most 2^31) back to a saturated signed value
    function automatic logic signed [31:0] fn_sat_quo(input logic [31:0] q, input logic neg);
        if (neg) begin
            return ~q + 32'd1;
        end
        return q[31] ? 32'h7FFF_FFFF : q;
    endfunction

endpackage

@@ design/ctc_sincos.sv @@
`timescale 1ns / 1ps
module ctc_sincos (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [25:0]  i_deg,
    output logic signed [31:0]  o_cos,
    output logic signed [31:0]  o_sin
);

    localparam int N = ctc_pkg::CORDIC_STEPS;

    logic [25:0] w_mag;
    logic [51:0] w_prod;
    logic [19:0] r_a;
    logic [25:0] r_mag;
    logic        r_neg;
    logic [5:0]  w_b;
    logic [31:0] w_q;
    logic [31:0] w_bam;
    logic        w_flip;
    logic [31:0] w_bam_f;

    logic signed [33:0] r_x [0:N];
    logic signed [33:0] r_y [0:N];
    logic signed [33:0] r_z [0:N];
    logic               r_flip [0:N];
    logic signed [31:0] r_cos;
    logic signed [31:0] r_sin;

    always_comb begin
        w_mag  = i_deg[25] ? 26'(-i_deg) : 26'(i_deg);
        w_prod = w_mag * ctc_pkg::RECIP_45;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= w_prod[50:31];
            r_mag <= w_mag;
            r_neg <= i_deg[25];
        end
    end

    // deg * 65536 / 360 = (mag / 45) * 8192 + remainder part from a table
    always_comb begin
        w_b     = 6'(r_mag - 26'(r_a) * 26'd45);
        w_q     = 32'({r_a, 13'd0}) + 32'(ctc_pkg::FRAC_TAB[w_b]);
        w_bam   = r_neg ? (~w_q + 32'd1) : w_q;
        w_flip  = (w_bam[31:30] == 2'b01) || (w_bam[31:30] == 2'b10);
        w_bam_f = w_flip ? (w_bam + 32'h8000_0000) : w_bam;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= ctc_pkg::CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= 34'($signed(w_bam_f));
            r_flip[0] <= w_flip;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - $signed({2'b00, ctc_pkg::ATAN_TAB[i]});
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + $signed({2'b00, ctc_pkg::ATAN_TAB[i]});
                end
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_flip[N] ? 32'(-r_x[N]) : 32'(r_x[N]);
            r_sin <= r_flip[N] ? 32'(-r_y[N]) : 32'(r_y[N]);
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

@@ design/ctc_sqrt.sv @@
`timescale 1ns / 1ps
module ctc_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    logic [33:0] r_rem  [0:31];
    logic [31:0] r_root [0:31];
    logic [63:0] r_rad  [0:31];

    // one root bit per stage, two radicand bits shifted in each time
    for (genvar k = 0; k < 32; k++) begin : g_stage
        logic [33:0] w_rem_in;
        logic [31:0] w_root_in;
        logic [63:0] w_rad_in;
        logic [35:0] w_cur;
        logic [35:0] w_try;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_rad_in  = r_rad[k-1];
        end

        assign w_cur = {w_rem_in, w_rad_in[63:62]};
        assign w_try = {2'b00, w_root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_cur >= w_try) begin
                    r_rem[k]  <= 34'(w_cur - w_try);
                    r_root[k] <= {w_root_in[30:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_cur[33:0];
                    r_root[k] <= {w_root_in[30:0], 1'b0};
                end
                r_rad[k] <= {w_rad_in[61:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[31];

endmodule

@@ design/ctc_div.sv @@
`timescale 1ns / 1ps
module ctc_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic [31:0] o_quo
);

    logic [31:0] r_rem [0:31];
    logic [30:0] r_low [0:31];
    logic [31:0] r_den [0:31];
    logic [30:0] r_q   [0:31];
    logic        r_ovf [0:31];

    // quotient at or above 2^31 only needs to be known as such
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= i_num[63:31] >= {1'b0, i_den};
            r_rem[0] <= i_num[62:31];
            r_low[0] <= i_num[30:0];
            r_den[0] <= i_den;
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 1; k < 32; k++) begin : g_stage
        logic [32:0] w_cur;
        assign w_cur = {r_rem[k-1], r_low[k-1][30]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_cur >= {1'b0, r_den[k-1]}) begin
                    r_rem[k] <= 32'(w_cur - {1'b0, r_den[k-1]});
                    r_q[k]   <= {r_q[k-1][29:0], 1'b1};
                end else begin
                    r_rem[k] <= w_cur[31:0];
                    r_q[k]   <= {r_q[k-1][29:0], 1'b0};
                end
                r_low[k] <= {r_low[k-1][29:0], 1'b0};
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_ovf[31] ? 32'h8000_0000 : {1'b0, r_q[31]};

endmodule

@@ design/coordinate_to_cartesian_unit.sv @@
// Coordinate to Cartesian conversion unit.
// Input stream (s_axis): x, y, z positions in Q16.16 and longitude/latitude
// in Q9.16 degrees, all in tdata. Output stream (m_axis): x, y, z and the
// vector length in Q16.16 on tdata, status on tuser (1 = failed, outputs 0).
// The coordinate mode is a 3-bit register written through i_cfg_wr_en /
// i_cfg_wr_data; write it only while no item is in flight.
// Throughput: one item per cycle unless a receiver stall holds the pipeline.
// Items pass through the CORDIC rotators, two square-root pipelines (32
// stages each) and two divider pipelines (32 stages each) in series.
// Reset (synchronous, active low) clears all valid bits and sets the mode
// to cartesian. When the receiver stalls, the result stays in the output
// register and the pipeline keeps advancing as long as its last stage is
// empty, so new items are still taken until an item reaches the last stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module coordinate_to_cartesian_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_wr_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], lon_deg[121:96],
    // lat_deg[147:122], zero pad[151:148]
    input  logic [151:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_length[127:96]
    output logic [127:0] o_m_axis_tdata,
    // status[0]
    output logic         o_m_axis_tuser
);

    localparam int SC_LAT  = ctc_pkg::SC_LAT;
    localparam int SQ_LAT  = ctc_pkg::SQ_LAT;
    localparam int DIV_LAT = ctc_pkg::DIV_LAT;

    logic [2:0] r_coord_mode;
    logic       w_adv;
    logic       w_out_ld;

    ctc_pkg::t_side r_s0_side, n_s0_side;
    logic signed [25:0] r_lon, r_lat;
    ctc_pkg::t_side r_d1 [0:SC_LAT-1];
    ctc_pkg::t_side r_p_side, r_q_side, n_q_side;
    ctc_pkg::t_side r_d2 [0:SQ_LAT-1];
    ctc_pkg::t_side r_r_side, n_r_side;
    ctc_pkg::t_side r_d3 [0:DIV_LAT-1];
    ctc_pkg::t_side r_u_side, n_u_side, r_v_side;
    ctc_pkg::t_side r_d4 [0:DIV_LAT-1];
    ctc_pkg::t_side r_w_side, n_w_side, r_m_side, r_n_side;
    ctc_pkg::t_side r_d5 [0:SQ_LAT-1];
    ctc_pkg::t_side w_d1, w_d2, w_d3, w_d4, w_d5;

    logic signed [31:0] w_cl, w_sl, w_co, w_so, w_pm;
    logic signed [63:0] r_p_mx, r_p_my;
    logic signed [31:0] r_p_zt;
    logic [63:0] r_p_sqx, r_p_sqy, n_p_sqx, n_p_sqy;
    logic [63:0] w_q_sum, r_q_rad, n_q_rad;
    logic [31:0] w_rt_a, w_rt_b;
    logic [63:0] r_r_nx, r_r_ny, r_r_nz, n_r_nx, n_r_ny, n_r_nz;
    logic [31:0] r_r_den;
    logic [31:0] w_qx, w_qy, w_qz, w_rqx, w_rqy;
    logic [63:0] r_v_nx, r_v_ny, n_v_nx, n_v_ny;
    logic [31:0] r_v_den;
    logic [63:0] r_m_sx, r_m_sy, r_m_sz, n_m_sx, n_m_sy, n_m_sz;
    logic [63:0] r_n_rad;
    logic signed [31:0] r_o_x, r_o_y, r_o_z;
    logic [31:0] r_o_len;
    logic        r_o_fail, r_o_valid;

    // pipeline moves when the output register can take the last stage
    // or the last stage holds nothing
    assign w_out_ld        = i_m_axis_tready || !r_o_valid;
    assign w_adv           = w_out_ld || !w_d5.valid;
    assign o_s_axis_tready = w_adv;

    assign w_d1 = r_d1[SC_LAT-1];
    assign w_d2 = r_d2[SQ_LAT-1];
    assign w_d3 = r_d3[DIV_LAT-1];
    assign w_d4 = r_d4[DIV_LAT-1];
    assign w_d5 = r_d5[SQ_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord_mode <= 3'(ctc_pkg::MODE_CART);
        end else if (i_cfg_wr_en) begin
            r_coord_mode <= i_cfg_wr_data;
        end
    end

    always_comb begin
        n_s0_side       = '0;
        n_s0_side.valid = i_s_axis_tvalid;
        n_s0_side.mode  = r_coord_mode;
        n_s0_side.px    = i_s_axis_tdata[31:0];
        n_s0_side.py    = i_s_axis_tdata[63:32];
        n_s0_side.pz    = i_s_axis_tdata[95:64];
        n_s0_side.x     = i_s_axis_tdata[31:0];
        n_s0_side.y     = i_s_axis_tdata[63:32];
        n_s0_side.z     = i_s_axis_tdata[95:64];
    end

    ctc_sincos u_sc_lon (
        .i_clk (i_clk), .i_en (w_adv), .i_deg (r_lon), .o_cos (w_cl), .o_sin (w_sl)
    );
    ctc_sincos u_sc_lat (
        .i_clk (i_clk), .i_en (w_adv), .i_deg (r_lat), .o_cos (w_co), .o_sin (w_so)
    );

    // trig products for polar / sky modes, squares for unit / tangent modes
    always_comb begin
        w_pm    = (w_d1.mode == ctc_pkg::MODE_POLAR) ? w_so : w_co;
        n_p_sqx = ctc_pkg::fn_abs32(w_d1.px) * ctc_pkg::fn_abs32(w_d1.px);
        n_p_sqy = ctc_pkg::fn_abs32(w_d1.py) * ctc_pkg::fn_abs32(w_d1.py);
    end

    always_comb begin
        n_q_side = r_p_side;
        n_q_rad  = '0;
        w_q_sum  = r_p_sqx + r_p_sqy;
        case (r_p_side.mode)
            ctc_pkg::MODE_CART: begin
            end
            ctc_pkg::MODE_UNIT: begin
                if (w_q_sum >= 64'h1_0000_0000) begin
                    n_q_side.fail = 1'b1;
                end else begin
                    n_q_rad = 64'h1_0000_0000 - w_q_sum;
                end
            end
            ctc_pkg::MODE_POLAR, ctc_pkg::MODE_SKY: begin
                n_q_side.x = 32'((r_p_mx + 64'sd8796093022208) >>> 44);
                n_q_side.y = 32'((r_p_my + 64'sd8796093022208) >>> 44);
                if (r_p_side.mode == ctc_pkg::MODE_POLAR) begin
                    n_q_side.y = -32'((r_p_my + 64'sd8796093022208) >>> 44);
                end
                n_q_side.z = 32'(($signed({r_p_zt[31], r_p_zt}) + 33'sd8192) >>> 14);
            end
            ctc_pkg::MODE_TAN: begin
                n_q_rad = 64'h1_0000_0000 + w_q_sum;
            end
            default: begin
                n_q_side.fail = 1'b1;
            end
        endcase
    end

    ctc_sqrt u_sqrt_a (.i_clk (i_clk), .i_en (w_adv), .i_rad (r_q_rad), .o_root (w_rt_a));

    // unit-mode z, tangent-mode divide setup
    always_comb begin
        n_r_side = w_d2;
        if (w_d2.mode == ctc_pkg::MODE_UNIT && !w_d2.fail) begin
            n_r_side.z = $signed(w_rt_a);
        end
        n_r_nx = {16'd0, ctc_pkg::fn_abs32(w_d2.px), 16'd0} + {33'd0, w_rt_a[31:1]};
        n_r_ny = {16'd0, ctc_pkg::fn_abs32(w_d2.py), 16'd0} + {33'd0, w_rt_a[31:1]};
        n_r_nz = 64'h1_0000_0000 + {33'd0, w_rt_a[31:1]};
    end

    ctc_div u_div_x (.i_clk (i_clk), .i_en (w_adv), .i_num (r_r_nx), .i_den (r_r_den),
                     .o_quo (w_qx));
    ctc_div u_div_y (.i_clk (i_clk), .i_en (w_adv), .i_num (r_r_ny), .i_den (r_r_den),
                     .o_quo (w_qy));
    ctc_div u_div_z (.i_clk (i_clk), .i_en (w_adv), .i_num (r_r_nz), .i_den (r_r_den),
                     .o_quo (w_qz));

    always_comb begin
        n_u_side = w_d3;
        if (w_d3.mode == ctc_pkg::MODE_TAN) begin
            n_u_side.x = ctc_pkg::fn_sat_quo(w_qx, w_d3.px[31]);
            n_u_side.y = ctc_pkg::fn_sat_quo(w_qy, w_d3.py[31]);
            n_u_side.z = ctc_pkg::fn_sat_quo(w_qz, 1'b0);
        end
        n_u_side.resc = !w_d3.fail && (w_d3.mode != ctc_pkg::MODE_SKY) &&
                        (n_u_side.z > 0) && (w_d3.pz > 0);
    end

    // rescale so that z lands on the input z
    always_comb begin
        n_v_nx = ctc_pkg::fn_abs32(r_u_side.x) * ctc_pkg::fn_abs32(r_u_side.pz) +
                 {33'd0, r_u_side.z[31:1]};
        n_v_ny = ctc_pkg::fn_abs32(r_u_side.y) * ctc_pkg::fn_abs32(r_u_side.pz) +
                 {33'd0, r_u_side.z[31:1]};
    end

    ctc_div u_div_rx (.i_clk (i_clk), .i_en (w_adv), .i_num (r_v_nx), .i_den (r_v_den),
                      .o_quo (w_rqx));
    ctc_div u_div_ry (.i_clk (i_clk), .i_en (w_adv), .i_num (r_v_ny), .i_den (r_v_den),
                      .o_quo (w_rqy));

    always_comb begin
        n_w_side = w_d4;
        if (w_d4.resc) begin
            n_w_side.x = ctc_pkg::fn_sat_quo(w_rqx, w_d4.x[31]);
            n_w_side.y = ctc_pkg::fn_sat_quo(w_rqy, w_d4.y[31]);
            n_w_side.z = w_d4.pz;
        end
        if (w_d4.fail) begin
            n_w_side.x = '0;
            n_w_side.y = '0;
            n_w_side.z = '0;
        end
    end

    always_comb begin
        n_m_sx = ctc_pkg::fn_abs32(r_w_side.x) * ctc_pkg::fn_abs32(r_w_side.x);
        n_m_sy = ctc_pkg::fn_abs32(r_w_side.y) * ctc_pkg::fn_abs32(r_w_side.y);
        n_m_sz = ctc_pkg::fn_abs32(r_w_side.z) * ctc_pkg::fn_abs32(r_w_side.z);
    end

    ctc_sqrt u_sqrt_b (.i_clk (i_clk), .i_en (w_adv), .i_rad (r_n_rad), .o_root (w_rt_b));

    // item tags and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_side <= '0;
            r_p_side  <= '0;
            r_q_side  <= '0;
            r_r_side  <= '0;
            r_u_side  <= '0;
            r_v_side  <= '0;
            r_w_side  <= '0;
            r_m_side  <= '0;
            r_n_side  <= '0;
            for (int k = 0; k < SC_LAT; k++) begin
                r_d1[k] <= '0;
            end
            for (int k = 0; k < SQ_LAT; k++) begin
                r_d2[k] <= '0;
                r_d5[k] <= '0;
            end
            for (int k = 0; k < DIV_LAT; k++) begin
                r_d3[k] <= '0;
                r_d4[k] <= '0;
            end
        end else if (w_adv) begin
            r_s0_side <= n_s0_side;
            r_d1[0]   <= r_s0_side;
            for (int k = 1; k < SC_LAT; k++) begin
                r_d1[k] <= r_d1[k-1];
            end
            r_p_side <= w_d1;
            r_q_side <= n_q_side;
            r_d2[0]  <= r_q_side;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_d2[k] <= r_d2[k-1];
            end
            r_r_side <= n_r_side;
            r_d3[0]  <= r_r_side;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_d3[k] <= r_d3[k-1];
            end
            r_u_side <= n_u_side;
            r_v_side <= r_u_side;
            r_d4[0]  <= r_v_side;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_d4[k] <= r_d4[k-1];
            end
            r_w_side <= n_w_side;
            r_m_side <= r_w_side;
            r_n_side <= r_m_side;
            r_d5[0]  <= r_n_side;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_d5[k] <= r_d5[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lon   <= i_s_axis_tdata[121:96];
            r_lat   <= i_s_axis_tdata[147:122];
            r_p_mx  <= w_pm * w_cl;
            r_p_my  <= w_pm * w_sl;
            r_p_zt  <= (w_d1.mode == ctc_pkg::MODE_POLAR) ? w_co : w_so;
            r_p_sqx <= n_p_sqx;
            r_p_sqy <= n_p_sqy;
            r_q_rad <= n_q_rad;
            r_r_nx  <= n_r_nx;
            r_r_ny  <= n_r_ny;
            r_r_nz  <= n_r_nz;
            r_r_den <= w_rt_a;
            r_v_nx  <= n_v_nx;
            r_v_ny  <= n_v_ny;
            r_v_den <= r_u_side.z;
            r_m_sx  <= n_m_sx;
            r_m_sy  <= n_m_sy;
            r_m_sz  <= n_m_sz;
            r_n_rad <= r_m_sx + r_m_sy + r_m_sz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_ld) begin
            r_o_valid <= w_d5.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            r_o_x    <= w_d5.x;
            r_o_y    <= w_d5.y;
            r_o_z    <= w_d5.z;
            r_o_len  <= w_rt_b;
            r_o_fail <= w_d5.fail;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {r_o_len, r_o_z, r_o_y, r_o_x};
    assign o_m_axis_tuser  = r_o_fail;

    `CTC_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, r_o_valid && r_o_fail, o_m_axis_tdata == '0)
    `CTC_ASSERT_IMP(a_len_ge_z, i_clk, i_rst_n, r_o_valid, r_o_len >= ctc_pkg::fn_abs32(r_o_z))
    `CTC_ASSERT_NXT(a_last_held, i_clk, i_rst_n, r_o_valid && !i_m_axis_tready && w_d5.valid, w_d5.valid)

endmodule

@@ tb/ctc_checker.sv @@
`timescale 1ns / 1ps
module ctc_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_wr_data,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    input  logic [151:0] i_s_axis_tdata,
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic [127:0] i_m_axis_tdata,
    input  logic         i_m_axis_tuser,
    output int           o_errors,
    output int           o_pending
);

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        len;
        logic               status;
    } t_cart;

    t_cart       cart_q[$];
    logic [2:0]  mode_shadow;
    int          err_cnt = 0;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // round(a * num / den), sign-magnitude, saturated
    function automatic longint scale_div(input longint a, input longint unsigned num,
                                         input longint unsigned den);
        logic            neg;
        longint unsigned mag;
        longint unsigned q;
        neg = a < 0;
        mag = neg ? longint'(-a) : longint'(a);
        q = (mag * num + den / 2) / den;
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return clamp32(neg ? -longint'(q) : longint'(q));
    endfunction

    // cos/sin in Q30 of a Q9.16 degree angle
    function automatic void deg_sincos(input longint deg, output longint c,
                                       output longint s);
        logic            neg;
        logic            flip;
        longint unsigned mag;
        longint unsigned q;
        logic [31:0]     bam;
        longint          x, y, z, dx, dy;
        neg = deg < 0;
        mag = neg ? longint'(-deg) : longint'(deg);
        q = (mag * 65536 + 180) / 360;
        bam = neg ? 32'(-q) : 32'(q);
        flip = 1'b0;
        x = longint'(ctc_pkg::CORDIC_GAIN);
        y = 0;
        if (bam[31:30] == 2'd1 || bam[31:30] == 2'd2) begin
            bam = bam + 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'(signed'(bam));
        for (int i = 0; i < ctc_pkg::CORDIC_STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ctc_pkg::ATAN_TAB[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ctc_pkg::ATAN_TAB[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint q30_prod(input longint a, input longint b);
        return (a * b + (64'sd1 << 43)) >>> 44;
    endfunction

    function automatic t_cart convert_position(input logic [2:0] mode,
                                               input logic [151:0] d);
        t_cart           r;
        longint          px, py, pz, lon, lat, x, y, z;
        longint          cl, sl, co, so;
        longint unsigned ax, ay, sum, len;
        logic            fail;
        px = longint'(signed'(d[31:0]));
        py = longint'(signed'(d[63:32]));
        pz = longint'(signed'(d[95:64]));
        lon = longint'(signed'(d[121:96]));
        lat = longint'(signed'(d[147:122]));
        x = px;
        y = py;
        z = pz;
        fail = 1'b0;
        case (mode)
            ctc_pkg::MODE_CART: begin
            end
            ctc_pkg::MODE_UNIT: begin
                ax = px < 0 ? -px : px;
                ay = py < 0 ? -py : py;
                sum = ax * ax + ay * ay;
                if (sum >= (64'd1 << 32)) fail = 1'b1;
                else z = longint'(int_sqrt((64'd1 << 32) - sum));
            end
            ctc_pkg::MODE_POLAR: begin
                deg_sincos(lon, cl, sl);
                deg_sincos(lat, co, so);
                x = q30_prod(so, cl);
                y = -q30_prod(so, sl);
                z = (co + (64'sd1 << 13)) >>> 14;
            end
            ctc_pkg::MODE_SKY: begin
                deg_sincos(lon, cl, sl);
                deg_sincos(lat, co, so);
                x = q30_prod(co, cl);
                y = q30_prod(co, sl);
                z = (so + (64'sd1 << 13)) >>> 14;
            end
            ctc_pkg::MODE_TAN: begin
                ax = px < 0 ? -px : px;
                ay = py < 0 ? -py : py;
                len = int_sqrt((64'd1 << 32) + ax * ax + ay * ay);
                x = scale_div(px, 65536, len);
                y = scale_div(py, 65536, len);
                z = scale_div(65536, 65536, len);
            end
            default: fail = 1'b1;
        endcase
        if (fail) begin
            r.x = '0;
            r.y = '0;
            r.z = '0;
            r.len = '0;
            r.status = 1'b1;
            return r;
        end
        // rescale so that z lands on the input z
        if (mode != ctc_pkg::MODE_SKY && z > 0 && pz > 0) begin
            x = scale_div(x, pz, z);
            y = scale_div(y, pz, z);
            z = pz;
        end
        x = clamp32(x);
        y = clamp32(y);
        z = clamp32(z);
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        sum = ax * ax + ay * ay;
        ax = z < 0 ? -z : z;
        sum = sum + ax * ax;
        r.x = x[31:0];
        r.y = y[31:0];
        r.z = z[31:0];
        r.len = int_sqrt(sum);
        r.status = 1'b0;
        return r;
    endfunction

    assign o_pending = cart_q.size();
    assign o_errors  = err_cnt;

    always @(posedge i_clk) begin
        t_cart e;
        t_cart a;
        if (!i_rst_n) begin
            mode_shadow <= ctc_pkg::MODE_CART;
        end else begin
            if (i_cfg_wr_en) mode_shadow <= i_cfg_wr_data;
            if (i_s_axis_tvalid && i_s_axis_tready)
                cart_q.push_back(convert_position(mode_shadow, i_s_axis_tdata));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                a.x = i_m_axis_tdata[31:0];
                a.y = i_m_axis_tdata[63:32];
                a.z = i_m_axis_tdata[95:64];
                a.len = i_m_axis_tdata[127:96];
                a.status = i_m_axis_tuser;
                if (cart_q.size() == 0) begin
                    $display("%0t: unexpected item x=%0d y=%0d z=%0d len=%0d st=%0b",
                             $time, a.x, a.y, a.z, a.len, a.status);
                    err_cnt++;
                end else begin
                    e = cart_q.pop_front();
                    if (a.x != e.x || a.y != e.y || a.z != e.z || a.len != e.len
                        || a.status != e.status) begin
                        $display("%0t: mismatch exp x=%0d y=%0d z=%0d len=%0d st=%0b",
                                 $time, e.x, e.y, e.z, e.len, e.status);
                        $display("%0t:          got x=%0d y=%0d z=%0d len=%0d st=%0b",
                                 $time, a.x, a.y, a.z, a.len, a.status);
                        err_cnt++;
                    end
                end
            end
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

    localparam int DRAIN_CYCLES = 220;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DEG90        = 5898240;
    localparam int DEG_MAX      = 23592960;

    logic         i_clk;
    logic         i_rst_n;
    logic         cfg_wr_en;
    logic [2:0]   cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;
    int           errors;
    int           pending;
    int           cycles = 0;
    logic         no_gaps;

    coordinate_to_cartesian_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser)
    );

    ctc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_s_axis_tvalid(s_tvalid),
        .i_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .i_m_axis_tdata (m_tdata),
        .i_m_axis_tuser (m_tuser),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // receiver backpressure
    initial begin
        int g;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            g = gap_len();
            if (g == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                repeat (g - 1) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [25:0] lon,
                             input logic [25:0] lat);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, lat, lon, pz, py, px};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // mode changes only with the pipeline drained
    task automatic write_mode(input logic [2:0] m);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [25:0] rand_angle();
        if ($urandom_range(0, 9) == 0)
            return 26'($urandom_range(0, 7) * DEG90 - 4 * DEG90);
        return 26'(int'($urandom_range(0, 2 * DEG_MAX)) - DEG_MAX);
    endfunction

    function automatic logic [31:0] rand_pos(input logic [2:0] m);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom();
        if (r == 1) return 32'($urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF);
        // unit and tangent inputs live mostly below magnitude one
        if (m == ctc_pkg::MODE_UNIT || m == ctc_pkg::MODE_TAN)
            return 32'(int'($urandom_range(0, 92000)) - 46000);
        return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
    endfunction

    function automatic logic [31:0] rand_z();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 32'(-int'($urandom_range(0, 1 << 20)));
        if (r < 4) return '0;
        if (r < 5) return $urandom();
        return 32'($urandom_range(1, 1 << 22));
    endfunction

    logic [2:0] mode_seq[13] = '{ctc_pkg::MODE_CART, ctc_pkg::MODE_UNIT,
                                 ctc_pkg::MODE_POLAR, ctc_pkg::MODE_UNSUP,
                                 ctc_pkg::MODE_SKY, ctc_pkg::MODE_TAN, 3'd6, 3'd7,
                                 ctc_pkg::MODE_POLAR, ctc_pkg::MODE_UNIT,
                                 ctc_pkg::MODE_TAN, ctc_pkg::MODE_SKY,
                                 ctc_pkg::MODE_CART};

    initial begin
        logic [2:0] m;
        no_gaps = 1'b0;
        i_rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 13; p++) begin
            m = mode_seq[p];
            write_mode(m);
            if (p < 8) begin
                // field extremes, quadrant edges, and a near-unit radius that
                // leaves a tiny z and forces a saturating rescale
                send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          26'(DEG_MAX), 26'(-DEG_MAX));
                send_item(32'd65535, 32'd0, 32'h7FFF_FFFF, 26'(DEG90), 26'(2 * DEG90));
                send_item('0, 32'hFFFF_0000, 32'h8000_0000, 26'(-DEG90), 26'(3 * DEG90));
            end
            no_gaps = (p % 4 == 2);
            for (int k = 0; k < 42; k++)
                send_item(rand_pos(m), rand_pos(m), rand_z(), rand_angle(), rand_angle());
            no_gaps = 1'b0;
        end

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
